[design/cmm_pkg.sv]
// Package for the complex matrix multiplier.
// Holds the fixed field widths and the phase codes of the shared multiplier.
// Depends on nothing.
package cmm_pkg;

  // Width of one real or imaginary part of an input element.
  localparam int PART_W = 16;
  // Width of one signed partial product.
  localparam int PROD_W = 2 * PART_W;
  // Width of one accumulated real or imaginary sum.
  localparam int SUM_W = 37;

  // One stored complex element.
  typedef struct packed {
    logic signed [PART_W-1:0] re;
    logic signed [PART_W-1:0] im;
  } elem_t;

  // Which partial product the shared multiplier forms in a cycle.
  typedef enum logic [1:0] {
    PH_RR = 2'd0,  // a.re * b.re, added to the real sum
    PH_II = 2'd1,  // a.im * b.im, subtracted from the real sum
    PH_RI = 2'd2,  // a.re * b.im, added to the imaginary sum
    PH_IR = 2'd3   // a.im * b.re, added to the imaginary sum
  } phase_t;

endpackage

[design/cmm_in_if.sv]
// Input channel of the complex matrix multiplier: one matrix element per transaction.
// Depends on cmm_pkg for the part width.
interface cmm_in_if;
  logic                               valid;
  logic                               ready;
  logic                               kind;
  logic signed [cmm_pkg::PART_W-1:0]  real_part;
  logic signed [cmm_pkg::PART_W-1:0]  imag_part;

  modport source (output valid, kind, real_part, imag_part, input ready);
  modport sink   (input valid, kind, real_part, imag_part, output ready);
endinterface

[design/cmm_out_if.sv]
// Output channel of the complex matrix multiplier: one product entry per transaction.
// Depends on cmm_pkg for the sum width.
interface cmm_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [cmm_pkg::SUM_W-1:0]  real_sum;
  logic signed [cmm_pkg::SUM_W-1:0]  imag_sum;
  logic                              last_entry;

  modport source (output valid, real_sum, imag_sum, last_entry, input ready);
  modport sink   (input valid, real_sum, imag_sum, last_entry, output ready);
endinterface

[design/complex_matrix_multiply_top.sv]
// Complex matrix multiplier C = A * B with one shared 16x16 signed multiplier.
// Loading: one element per cycle; elements for a matrix that is already full are dropped.
// Computing: each product entry runs, per inner step, one store read and four multiplies,
// then one drain and one output step; an output stall holds the output step. No input
// is taken while computing.
// Reset (rst, synchronous) clears the fill counters, sequencer and output valid, not the stores.
// Depends on cmm_pkg, cmm_in_if and cmm_out_if.
module complex_matrix_multiply_top #(
  parameter int ROWS_A = 4,
  parameter int INNER  = 4,
  parameter int COLS_B = 4
) (
  input  logic         clk,
  input  logic         rst,
  cmm_in_if.sink       elements,
  cmm_out_if.source    products
);

  // Store sizes and the widths of the counters and addresses that walk them.
  localparam int A_DEPTH = ROWS_A * INNER;
  localparam int B_DEPTH = INNER * COLS_B;
  localparam int A_AW    = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
  localparam int B_AW    = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
  localparam int CA_W    = $clog2(A_DEPTH + 1);
  localparam int CB_W    = $clog2(B_DEPTH + 1);
  localparam int I_W     = (ROWS_A > 1) ? $clog2(ROWS_A) : 1;
  localparam int J_W     = (COLS_B > 1) ? $clog2(COLS_B) : 1;
  localparam int P_W     = (INNER > 1) ? $clog2(INNER) : 1;

  localparam int PW = cmm_pkg::PART_W;
  localparam int MW = cmm_pkg::PROD_W;
  localparam int SW = cmm_pkg::SUM_W;

  // The sequencer. LOAD takes elements; FETCH reads one A and one B element;
  // MAC runs the four partial products through the multiplier; DRAIN lets the
  // last product reach the accumulators; EMIT hands the entry to the output register.
  typedef enum logic [2:0] {
    S_LOAD,
    S_FETCH,
    S_MAC,
    S_DRAIN,
    S_EMIT
  } state_t;

  state_t state;

  // Element stores, one per matrix, filled in row-major order.
  cmm_pkg::elem_t a_mem [A_DEPTH];
  cmm_pkg::elem_t b_mem [B_DEPTH];
  cmm_pkg::elem_t a_rd;
  cmm_pkg::elem_t b_rd;

  logic [CA_W-1:0] a_cnt;
  logic [CB_W-1:0] b_cnt;
  logic [CA_W-1:0] a_cnt_next;
  logic [CB_W-1:0] b_cnt_next;

  // Walk over the stores while computing. a_base is the start of the current
  // row of A; b_col is the start of the current column of B.
  logic [A_AW-1:0] a_addr;
  logic [A_AW-1:0] a_base;
  logic [B_AW-1:0] b_addr;
  logic [B_AW-1:0] b_col;
  logic [I_W-1:0]  row;
  logic [J_W-1:0]  col;
  logic [P_W-1:0]  step;

  cmm_pkg::phase_t phase;
  cmm_pkg::phase_t prod_ph;
  logic            prod_vld;

  logic signed [PW-1:0] mul_a;
  logic signed [PW-1:0] mul_b;
  logic signed [MW-1:0] mul_res;
  logic signed [MW-1:0] prod;
  logic signed [SW-1:0] prod_ext;
  logic signed [SW-1:0] acc_re;
  logic signed [SW-1:0] acc_im;

  logic signed [SW-1:0] out_re;
  logic signed [SW-1:0] out_im;
  logic                 out_last;
  logic                 out_vld;

  logic accept;
  logic a_wr;
  logic b_wr;
  logic both_full;
  logic last_step;
  logic last_row;
  logic last_col;
  logic out_free;

  // Handshake and fill bookkeeping.
  assign elements.ready = (state == S_LOAD);
  assign accept         = elements.valid && elements.ready;

  // An element is written only while its store still has room.
  assign a_wr = accept && !elements.kind && (a_cnt < CA_W'(A_DEPTH));
  assign b_wr = accept &&  elements.kind && (b_cnt < CB_W'(B_DEPTH));

  assign a_cnt_next = a_wr ? CA_W'(a_cnt + 1'b1) : a_cnt;
  assign b_cnt_next = b_wr ? CB_W'(b_cnt + 1'b1) : b_cnt;
  assign both_full  = (a_cnt_next == CA_W'(A_DEPTH)) && (b_cnt_next == CB_W'(B_DEPTH));

  assign last_step = (step == P_W'(INNER - 1));
  assign last_row  = (row == I_W'(ROWS_A - 1));
  assign last_col  = (col == J_W'(COLS_B - 1));

  // The output register can take a new entry when empty or being drained this cycle.
  assign out_free = !out_vld || products.ready;

  // Operand selection for the shared multiplier.
  always_comb begin
    case (phase)
      cmm_pkg::PH_RR: begin
        mul_a = a_rd.re;
        mul_b = b_rd.re;
      end
      cmm_pkg::PH_II: begin
        mul_a = a_rd.im;
        mul_b = b_rd.im;
      end
      cmm_pkg::PH_RI: begin
        mul_a = a_rd.re;
        mul_b = b_rd.im;
      end
      cmm_pkg::PH_IR: begin
        mul_a = a_rd.im;
        mul_b = b_rd.re;
      end
      default: begin
        mul_a = a_rd.re;
        mul_b = b_rd.re;
      end
    endcase
  end

  assign mul_res  = mul_a * mul_b;
  assign prod_ext = {{(SW - MW){prod[MW-1]}}, prod};

  // Store writes during loading and registered reads during the walk.
  always_ff @(posedge clk) begin
    if (a_wr) begin
      a_mem[a_cnt[A_AW-1:0]] <= {elements.real_part, elements.imag_part};
    end
    if (b_wr) begin
      b_mem[b_cnt[B_AW-1:0]] <= {elements.real_part, elements.imag_part};
    end
    if (state == S_FETCH) begin
      a_rd <= a_mem[a_addr];
      b_rd <= b_mem[b_addr];
    end
  end

  // Sequencer, accumulators and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_LOAD;
      a_cnt    <= '0;
      b_cnt    <= '0;
      prod_vld <= 1'b0;
      out_vld  <= 1'b0;
    end else begin
      // The multiplier result is registered every cycle; it is only
      // accumulated in the cycle after a MAC cycle.
      prod     <= mul_res;
      prod_ph  <= phase;
      prod_vld <= (state == S_MAC);

      if (prod_vld) begin
        case (prod_ph)
          cmm_pkg::PH_RR: acc_re <= acc_re + prod_ext;
          cmm_pkg::PH_II: acc_re <= acc_re - prod_ext;
          cmm_pkg::PH_RI: acc_im <= acc_im + prod_ext;
          cmm_pkg::PH_IR: acc_im <= acc_im + prod_ext;
          default: acc_re <= acc_re;
        endcase
      end

      // A new entry fills the output register; otherwise it empties once taken.
      if (state == S_EMIT && out_free) begin
        out_vld <= 1'b1;
      end else if (products.ready) begin
        out_vld <= 1'b0;
      end

      case (state)
        S_LOAD: begin
          if (both_full) begin
            // The transaction that completes both matrices starts the product;
            // both counters return to zero for the next pair of matrices.
            a_cnt  <= '0;
            b_cnt  <= '0;
            a_addr <= '0;
            a_base <= '0;
            b_addr <= '0;
            b_col  <= '0;
            row    <= '0;
            col    <= '0;
            step   <= '0;
            acc_re <= '0;
            acc_im <= '0;
            state  <= S_FETCH;
          end else begin
            a_cnt <= a_cnt_next;
            b_cnt <= b_cnt_next;
          end
        end

        S_FETCH: begin
          phase <= cmm_pkg::PH_RR;
          state <= S_MAC;
        end

        S_MAC: begin
          phase <= cmm_pkg::phase_t'(phase + 2'd1);
          if (phase == cmm_pkg::PH_IR) begin
            if (last_step) begin
              state <= S_DRAIN;
            end else begin
              // Next inner step: along the row of A, down the column of B.
              step   <= P_W'(step + 1'b1);
              a_addr <= A_AW'(a_addr + 1'b1);
              b_addr <= B_AW'(b_addr + B_AW'(COLS_B));
              state  <= S_FETCH;
            end
          end
        end

        S_DRAIN: begin
          state <= S_EMIT;
        end

        S_EMIT: begin
          if (out_free) begin
            out_re   <= acc_re;
            out_im   <= acc_im;
            out_last <= last_row && last_col;
            acc_re   <= '0;
            acc_im   <= '0;
            step     <= '0;
            if (last_col) begin
              // Move to the next row of A and back to the first column of B.
              col    <= '0;
              row    <= I_W'(row + 1'b1);
              b_col  <= '0;
              b_addr <= '0;
              a_base <= A_AW'(a_base + A_AW'(INNER));
              a_addr <= A_AW'(a_base + A_AW'(INNER));
            end else begin
              col    <= J_W'(col + 1'b1);
              b_col  <= B_AW'(b_col + 1'b1);
              b_addr <= B_AW'(b_col + 1'b1);
              a_addr <= a_base;
            end
            if (last_row && last_col) begin
              state <= S_LOAD;
            end else begin
              state <= S_FETCH;
            end
          end
        end

        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  assign products.valid      = out_vld;
  assign products.real_sum   = out_re;
  assign products.imag_sum   = out_im;
  assign products.last_entry = out_last;

endmodule
